/* hw/rtl/agpr_pkg.sv */
// Shared types and constants for the axial gradient parameter range block.
`timescale 1ns / 1ps

package agpr_pkg;

  // Fraction bits of the result format; (1 << FRAC_BITS) stands for one.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned BoundW    = FRAC_BITS + 1;

  // Fixed arithmetic widths that follow from the 32-bit Q16.16 fields.
  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;      // difference of two coordinates
  localparam int unsigned ProdW  = 2 * DiffW;       // product of two differences
  localparam int unsigned SumW   = ProdW + 1;       // sum of two products
  localparam int unsigned NumW   = SumW + 1;        // base plus one step sum
  localparam int unsigned DenW   = ProdW;           // squared length, never negative
  localparam int unsigned RemW   = DenW + 1;        // divider remainder after a shift

  localparam int unsigned CfgIdxW = 2;

  localparam logic [BoundW-1:0] BoundOne  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [BoundW-1:0] BoundZero = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartX = 2'd0,
    CfgStartY = 2'd1,
    CfgEndX   = 2'd2,
    CfgEndY   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] box_left;
    logic signed [CoordW-1:0] box_top;
    logic signed [CoordW-1:0] box_right;
    logic signed [CoordW-1:0] box_bottom;
  } box_beat_t;

  typedef struct packed {
    logic [BoundW-1:0] lower_bound;
    logic [BoundW-1:0] upper_bound;
  } range_beat_t;

  // Saturation decision for one bound, made before the divider starts.
  typedef struct packed {
    logic sat;  // result is forced, the quotient is ignored
    logic one;  // forced result is one rather than zero
  } bound_ctl_t;

endpackage

/* hw/rtl/axial_gradient_param_range.sv */
// Top level of the axial gradient parameter range pipeline.
`timescale 1ns / 1ps

// For a linear gradient from a start point to an end point held in four
// configuration registers, each input beat carries one box and each output
// beat carries the lowest and highest gradient parameter over its corners,
// clamped to [0, 1] as unsigned Q1.FRAC_BITS (one is 1 << FRAC_BITS).
// Coinciding endpoints give zero for both bounds. The block is a
// pipeline that takes one box every cycle while the output is not
// stalled. The depth is set by the restoring divider, which resolves
// one quotient bit per stage for both bounds side by side; six further
// stages hold the coordinate differences, the six 33 x 33 bit products,
// two rows of adders, the saturation decision and the output register.
// Stalls collapse bubbles stage by stage, so a box is still taken while
// a finished result waits as long as any stage is empty. Configuration
// writes are registered and must only be made while no box is in flight.
module axial_gradient_param_range
  import agpr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CoordW-1:0]   cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  box_beat_t           in_data_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output range_beat_t         out_data_o
);

  // Stage numbering along the pipeline.
  localparam int unsigned StDiff = 0;
  localparam int unsigned StMul  = 1;
  localparam int unsigned StSum  = 2;
  localparam int unsigned StAdd  = 3;
  localparam int unsigned StInit = 4;
  localparam int unsigned StOut  = StInit + FRAC_BITS + 1;
  localparam int unsigned NumSt  = StOut + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic signed [CoordW-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgStartX: start_x_q <= cfg_data_i;
        CfgStartY: start_y_q <= cfg_data_i;
        CfgEndX:   end_x_q   <= cfg_data_i;
        CfgEndY:   end_y_q   <= cfg_data_i;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. A stage may load when it is empty or when the stage after
  // it moves on, so a stall only backs up as far as the first bubble.
  // ---------------------------------------------------------------------------
  logic [NumSt-1:0] vld_q, vld_d;
  logic [NumSt:0]   rdy;

  always_comb begin
    rdy[NumSt] = !out_stall_i;
    for (int i = NumSt - 1; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int i = 1; i < NumSt; i++) begin
      if (rdy[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[StOut];

  // ---------------------------------------------------------------------------
  // Stage: coordinate differences, all 33 bits signed.
  // ---------------------------------------------------------------------------
  logic signed [DiffW-1:0] dx_d, dy_d, ox_d, oy_d, wx_d, wy_d;
  logic signed [DiffW-1:0] dx_q, dy_q, ox_q, oy_q, wx_q, wy_q;

  assign dx_d = DiffW'(end_x_q) - DiffW'(start_x_q);
  assign dy_d = DiffW'(end_y_q) - DiffW'(start_y_q);
  assign ox_d = DiffW'(in_data_i.box_left) - DiffW'(start_x_q);
  assign oy_d = DiffW'(in_data_i.box_top) - DiffW'(start_y_q);
  assign wx_d = DiffW'(in_data_i.box_right) - DiffW'(in_data_i.box_left);
  assign wy_d = DiffW'(in_data_i.box_bottom) - DiffW'(in_data_i.box_top);

  always_ff @(posedge clk_i) begin
    if (rdy[StDiff]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      ox_q <= ox_d;
      oy_q <= oy_d;
      wx_q <= wx_d;
      wy_q <= wy_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: the six products. The squared length, the projection of the
  // reference corner, and the width and height steps along the gradient axis.
  // ---------------------------------------------------------------------------
  logic signed [ProdW-1:0] pxx_d, pyy_d, pbx_d, pby_d, psx_d, psy_d;
  logic signed [ProdW-1:0] pxx_q, pyy_q, pbx_q, pby_q, psx_q, psy_q;

  assign pxx_d = dx_q * dx_q;
  assign pyy_d = dy_q * dy_q;
  assign pbx_d = ox_q * dx_q;
  assign pby_d = oy_q * dy_q;
  assign psx_d = wx_q * dx_q;
  assign psy_d = wy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (rdy[StMul]) begin
      pxx_q <= pxx_d;
      pyy_q <= pyy_d;
      pbx_q <= pbx_d;
      pby_q <= pby_d;
      psx_q <= psx_d;
      psy_q <= psy_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: first adder row. Negative steps lower the minimum, the others
  // raise the maximum, so they are gathered into two separate sums here.
  // ---------------------------------------------------------------------------
  logic        [DenW-1:0]  den_s_d, den_s_q;
  logic signed [SumW-1:0]  base_d, sneg_d, spos_d;
  logic signed [SumW-1:0]  base_q, sneg_q, spos_q;
  logic signed [ProdW-1:0] negx, negy, posx, posy;

  assign negx = psx_q[ProdW-1] ? psx_q : '0;
  assign negy = psy_q[ProdW-1] ? psy_q : '0;
  assign posx = psx_q[ProdW-1] ? '0 : psx_q;
  assign posy = psy_q[ProdW-1] ? '0 : psy_q;

  // Both squares are below 2^64, so their sum fits without a sign bit.
  assign den_s_d = DenW'(pxx_q + pyy_q);
  assign base_d  = SumW'(pbx_q) + SumW'(pby_q);
  assign sneg_d  = SumW'(negx) + SumW'(negy);
  assign spos_d  = SumW'(posx) + SumW'(posy);

  always_ff @(posedge clk_i) begin
    if (rdy[StSum]) begin
      den_s_q <= den_s_d;
      base_q  <= base_d;
      sneg_q  <= sneg_d;
      spos_q  <= spos_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: second adder row, the unscaled lowest and highest parameters.
  // ---------------------------------------------------------------------------
  logic        [DenW-1:0] den_a_q;
  logic signed [NumW-1:0] lo_d, hi_d, lo_q, hi_q;

  assign lo_d = NumW'(base_q) + NumW'(sneg_q);
  assign hi_d = NumW'(base_q) + NumW'(spos_q);

  always_ff @(posedge clk_i) begin
    if (rdy[StAdd]) begin
      den_a_q <= den_s_q;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: the first stage settles saturation and loads the remainders,
  // then each following stage produces one quotient bit per bound.
  // ---------------------------------------------------------------------------
  logic [DenW-1:0]      dden_q [FRAC_BITS+1];
  logic [RemW-1:0]      rlo_q  [FRAC_BITS+1];
  logic [RemW-1:0]      rhi_q  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] qlo_q  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] qhi_q  [FRAC_BITS+1];
  bound_ctl_t           clo_q  [FRAC_BITS+1];
  bound_ctl_t           chi_q  [FRAC_BITS+1];

  bound_ctl_t      clo_d, chi_d;
  logic            den_zero;
  logic [RemW-1:0] den_ext;

  assign den_zero = (den_a_q == '0);
  assign den_ext  = {1'b0, den_a_q};

  // A ratio at or below zero clamps to zero, one at or above one clamps to
  // one; only a ratio strictly inside the interval needs the divider.
  always_comb begin
    clo_d.sat = den_zero || lo_q[NumW-1] || (lo_q == '0)
                || (lo_q[NumW-2:0] >= den_ext);
    clo_d.one = !den_zero && !lo_q[NumW-1] && (lo_q[NumW-2:0] >= den_ext);
    chi_d.sat = den_zero || hi_q[NumW-1] || (hi_q == '0)
                || (hi_q[NumW-2:0] >= den_ext);
    chi_d.one = !den_zero && !hi_q[NumW-1] && (hi_q[NumW-2:0] >= den_ext);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StInit]) begin
      dden_q[0] <= den_a_q;
      rlo_q[0]  <= lo_q[NumW-2:0];
      rhi_q[0]  <= hi_q[NumW-2:0];
      qlo_q[0]  <= '0;
      qhi_q[0]  <= '0;
      clo_q[0]  <= clo_d;
      chi_q[0]  <= chi_d;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
    logic [RemW-1:0] dext, slo, shi, rlo_d, rhi_d;
    logic            glo, ghi;

    // For an unsaturated bound the remainder stays below the divisor, so its
    // top bit is always zero and the doubled value still fits.
    assign dext  = {1'b0, dden_q[k-1]};
    assign slo   = {rlo_q[k-1][RemW-2:0], 1'b0};
    assign shi   = {rhi_q[k-1][RemW-2:0], 1'b0};
    assign glo   = (slo >= dext);
    assign ghi   = (shi >= dext);
    assign rlo_d = glo ? (slo - dext) : slo;
    assign rhi_d = ghi ? (shi - dext) : shi;

    always_ff @(posedge clk_i) begin
      if (rdy[StInit+k]) begin
        dden_q[k] <= dden_q[k-1];
        rlo_q[k]  <= rlo_d;
        rhi_q[k]  <= rhi_d;
        qlo_q[k]  <= {qlo_q[k-1][FRAC_BITS-2:0], glo};
        qhi_q[k]  <= {qhi_q[k-1][FRAC_BITS-2:0], ghi};
        clo_q[k]  <= clo_q[k-1];
        chi_q[k]  <= chi_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: pick the quotient or the saturated value.
  // ---------------------------------------------------------------------------
  range_beat_t out_d, out_q;

  always_comb begin
    if (clo_q[FRAC_BITS].sat) begin
      out_d.lower_bound = clo_q[FRAC_BITS].one ? BoundOne : BoundZero;
    end else begin
      out_d.lower_bound = {1'b0, qlo_q[FRAC_BITS]};
    end
    if (chi_q[FRAC_BITS].sat) begin
      out_d.upper_bound = chi_q[FRAC_BITS].one ? BoundOne : BoundZero;
    end else begin
      out_d.upper_bound = {1'b0, qhi_q[FRAC_BITS]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StOut]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  // An accepted box always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[StDiff])
    else $error("accepted box did not enter the pipeline");

  // The last divider stage keeps a remainder below the divisor.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[StOut-1] && !clo_q[FRAC_BITS].sat)
      |-> (rlo_q[FRAC_BITS] < {1'b0, dden_q[FRAC_BITS]}))
    else $error("divider remainder not below divisor");

  // The lower bound never exceeds the upper bound.
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.lower_bound <= out_data_o.upper_bound))
    else $error("lower bound above upper bound");

  // No result goes beyond one.
  a_bound_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.upper_bound <= BoundOne))
    else $error("upper bound beyond one");
`endif

endmodule
